/* hw/rtl/pid_continuity_counter_table_macros.svh */
// assertion macros for the pid continuity counter table
`ifndef PID_CONTINUITY_COUNTER_TABLE_MACROS_SVH
`define PID_CONTINUITY_COUNTER_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcct check failed");

// next-cycle implication, checked out of reset
`define PCCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcct check failed");

`endif

/* hw/rtl/pcct_pkg.sv */
// shared types and constants for the pid continuity counter table
package pcct_pkg;

  localparam int PCCT_MAX_ENTRIES_DEF = 32;
  localparam int PID_W = 13;
  localparam int CC_W  = 4;
  localparam int ENT_W = PID_W + CC_W;

  // operation codes
  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS
  } pcct_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic issue;
    logic fin_hit;
    logic fin_miss;
  } pcct_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic avail;
    logic pending;
    logic hit;
  } pcct_sts_t;

endpackage

/* hw/rtl/pid_continuity_counter_table.sv */
// top level of the pid continuity counter table
//
//   channel   handshake       ports
//   input     start / busy    in_operation, in_pid, in_cc_in, in_decrement
//   result    out_valid       out_ok, out_cc_out
//
// A word is taken when start is high and busy is low. The table is read one
// entry per cycle from a single-port memory, so a word whose pid sits at entry
// k strobes its result once entry k has been read and compared, and a miss
// strobes once all count entries have been read (none on an empty table).
// busy is low again in the cycle the result strobes, and a new word may be
// taken in that cycle.
// Synchronous reset empties the table at once; no clearing pass is needed.
// Results are shown for a single cycle and cannot be held off.
`include "pid_continuity_counter_table_macros.svh"

module pid_continuity_counter_table import pcct_pkg::*; #(
  parameter int MAX_ENTRIES = PCCT_MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_operation,
  input  logic [PID_W-1:0] in_pid,
  input  logic [CC_W-1:0]  in_cc_in,
  input  logic             in_decrement,
  output logic             out_valid,
  output logic             out_ok,
  output logic [CC_W-1:0]  out_cc_out
);

  pcct_cmd_t cmd;
  pcct_sts_t sts;

  // controller
  pcct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath
  pcct_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_operation),
    .in_pid       (in_pid),
    .in_cc_in     (in_cc_in),
    .in_decrement (in_decrement),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_cc_out   (out_cc_out)
  );

  // checks
  `PCCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PCCT_ASSERT_NOW(a_result_idle, out_valid, !busy)
  `PCCT_ASSERT_NOW(a_fail_zero_cc, out_valid && !out_ok, out_cc_out == '0)
  `PCCT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `PCCT_ASSERT_NOW(a_finish_onehot, 1'b1, $onehot0({cmd.fin_hit, cmd.fin_miss, cmd.load}))

endmodule

/* hw/rtl/pcct_ctrl.sv */
// controller state machine for the pid continuity counter table
module pcct_ctrl import pcct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  pcct_sts_t sts,
  output pcct_cmd_t cmd,
  output logic      busy
);

  pcct_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // keep reading entries until a compare hits or the table runs out
        cmd.issue = sts.avail && !sts.hit;
        if (sts.hit) begin
          state_nxt = ST_HIT;
        end else if (!sts.avail && !sts.pending) begin
          state_nxt = ST_MISS;
        end
      end
      ST_HIT: begin
        cmd.fin_hit = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_MISS: begin
        cmd.fin_miss = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/pcct_dp.sv */
// datapath: entry memory, scan counter, compare and result registers
module pcct_dp import pcct_pkg::*; #(
  parameter int MAX_ENTRIES = PCCT_MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pcct_cmd_t        cmd,
  output pcct_sts_t        sts,
  input  logic             in_operation,
  input  logic [PID_W-1:0] in_pid,
  input  logic [CC_W-1:0]  in_cc_in,
  input  logic             in_decrement,
  output logic             out_valid,
  output logic             out_ok,
  output logic [CC_W-1:0]  out_cc_out
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // entry memory, one word holds pid and counter
  logic [ENT_W-1:0] table_mem_r [MAX_ENTRIES];

  logic             op_r;
  logic [PID_W-1:0] pid_r;
  logic [CC_W-1:0]  cc_r;
  logic             dec_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             rd_vld_r;
  logic [ENT_W-1:0] rd_data_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [CC_W-1:0]  out_cc_r, out_cc_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [ENT_W-1:0] wr_data;

  logic [PID_W-1:0] rd_pid;
  logic [CC_W-1:0]  rd_cc;
  logic             full;

  assign rd_pid = rd_data_r[ENT_W-1:CC_W];
  assign rd_cc  = rd_data_r[CC_W-1:0];
  assign full   = (count_r == CNT_W'(MAX_ENTRIES));

  // status back to the controller
  assign sts.avail   = (rd_idx_r < count_r);
  assign sts.pending = rd_vld_r;
  assign sts.hit     = rd_vld_r && (rd_pid == pid_r);

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      pid_r <= in_pid;
      cc_r  <= in_cc_in;
      dec_r <= in_decrement;
    end
  end

  // scan address and read-valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.load) begin
        rd_idx_r <= '0;
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
    end
  end

  // registered memory read, tagged with its entry index
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= table_mem_r[rd_idx_r[IDX_W-1:0]];
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
  end

  // write port, update and result selection
  always_comb begin
    wr_en         = 1'b0;
    wr_idx        = cmp_idx_r;
    wr_data       = {pid_r, cc_r};
    count_nxt     = count_r;
    out_valid_nxt = cmd.fin_hit || cmd.fin_miss;
    out_ok_nxt    = 1'b0;
    out_cc_nxt    = '0;
    if (cmd.fin_hit) begin
      out_ok_nxt = 1'b1;
      if (op_r == OP_GET) begin
        out_cc_nxt = rd_cc;
        wr_en      = dec_r;
        wr_data    = {rd_pid, rd_cc - CC_W'(1)};
      end else begin
        wr_en = 1'b1;
      end
    end else if (cmd.fin_miss) begin
      // append on set when room is left
      if (op_r == OP_SET && !full) begin
        wr_en      = 1'b1;
        wr_idx     = count_r[IDX_W-1:0];
        count_nxt  = count_r + CNT_W'(1);
        out_ok_nxt = 1'b1;
      end
    end
  end

  // memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem_r[wr_idx] <= wr_data;
    end
  end

  // fill count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_ok_r <= out_ok_nxt;
      out_cc_r <= out_cc_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_cc_out = out_cc_r;

endmodule
